[rtl/core/pcpmrb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package pcpmrb_pkg;

    localparam int MAX_BINS_DEF     = 512;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 18;
    localparam int ANG_W            = 18;
    localparam int CW               = 48;   // CORDIC x/y width
    localparam int ZW               = 30;   // angle accumulator width
    localparam int QW               = 19;   // quotient width
    localparam int HALF_PI_Z        = 26353589;
    localparam int INV_GAIN_Q20     = 636751;

    localparam logic [CFG_IDX_W-1:0] REG_HMIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HMAX  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RMIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RMAX  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ALOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_AHIGH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ASTEP = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_INF   = 3'd7;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic               command;
        logic signed [15:0] x_mm;
        logic signed [15:0] y_mm;
        logic signed [15:0] z_mm;
        logic               point_valid;
        logic [8:0]         read_bin;
    } in_item_t;

    typedef struct packed {
        logic [8:0]  bin_number;
        logic [15:0] range_mm;
        logic        no_return;
    } out_item_t;

    typedef struct packed {
        logic signed [15:0] height_min_mm;
        logic signed [15:0] height_max_mm;
        logic [15:0]        min_dist_mm;
        logic [15:0]        range_max_mm;
        logic signed [17:0] angle_low;
        logic signed [17:0] angle_high;
        logic [17:0]        angle_step;
        logic               empty_as_infinity;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_CORDIC, ST_GAIN, ST_CHECK, ST_DIV, ST_RD_MEM, ST_UPDATE,
        ST_READ, ST_RD_WAIT, ST_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic clr;        // clearing pass write
        logic load;       // capture input, start cordic
        logic cordic_step;
        logic gain;       // range multiply
        logic div_start;  // start both dividers
        logic div_step;
        logic mem_rd;     // read bin at q
        logic update;     // write min
        logic rd_bin;     // read read_bin
        logic rd_clr;     // empty the bin just read
        logic out_load;
    } ctl_t;

    typedef struct packed {
        logic clr_done;
        logic keep;       // point passes filters
        logic div_done;
        logic cmd_read;
        logic in_range;   // early drop: invalid/height
    } sts_t;

    function automatic logic [ZW-1:0] atan_entry(input int i);
        logic [ZW-1:0] r;
        r = '0;
        case (i)
            0: r = ZW'(13176795);
            1: r = ZW'(7778716);
            2: r = ZW'(4110060);
            3: r = ZW'(2086331);
            4: r = ZW'(1047214);
            5: r = ZW'(524117);
            6: r = ZW'(262123);
            7: r = ZW'(131069);
            default: r = ZW'(1) << (24 - i);
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/core/pcpmrb_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module pcpmrb_ctrl #(
    parameter int CORDIC_STEPS = pcpmrb_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_fire,
    output logic                 in_ready,
    input  wire logic            out_free,
    input  wire pcpmrb_pkg::sts_t sts,
    output pcpmrb_pkg::ctl_t     ctl
);
    import pcpmrb_pkg::*;

    localparam int SCW = $clog2(CORDIC_STEPS + 1);

    state_t           state_reg, state_next;
    logic [SCW-1:0]   cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                ctl.clr = 1'b1;
                if (sts.clr_done)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_fire)
                begin
                    ctl.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = sts.cmd_read ? ST_READ : ST_CORDIC;
                end
            end
            ST_CORDIC:
            begin
                if (!sts.in_range)
                    state_next = ST_IDLE;
                else
                begin
                    ctl.cordic_step = 1'b1;
                    cnt_next = cnt_reg + SCW'(1);
                    if (cnt_reg == SCW'(CORDIC_STEPS - 1))
                        state_next = ST_GAIN;
                end
            end
            ST_GAIN:
            begin
                ctl.gain   = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (sts.keep)
                begin
                    ctl.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
                else
                    state_next = ST_IDLE;
            end
            ST_DIV:
            begin
                ctl.div_step = 1'b1;
                if (sts.div_done)
                    state_next = ST_RD_MEM;
            end
            ST_RD_MEM:
            begin
                ctl.mem_rd = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                ctl.update = 1'b1;
                state_next = ST_IDLE;
            end
            ST_READ:
            begin
                ctl.rd_bin = 1'b1;
                state_next = ST_RD_WAIT;
            end
            ST_RD_WAIT:
            begin
                ctl.rd_clr = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

[rtl/core/pcpmrb_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
module pcpmrb_dp #(
    parameter int MAX_BINS     = pcpmrb_pkg::MAX_BINS_DEF,
    parameter int CORDIC_STEPS = pcpmrb_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire pcpmrb_pkg::in_item_t  in_item,
    input  wire pcpmrb_pkg::cfg_t      cfg,
    input  wire pcpmrb_pkg::ctl_t      ctl,
    output pcpmrb_pkg::sts_t           sts,
    output pcpmrb_pkg::out_item_t      res
);
    import pcpmrb_pkg::*;

    localparam int BW  = $clog2(MAX_BINS);
    localparam int SCW = $clog2(CORDIC_STEPS + 1);

    // ---------------- capture / cordic ----------------
    logic signed [CW-1:0] x_reg, y_reg;
    logic signed [ZW-1:0] z_reg;
    logic [SCW-1:0]       i_reg;
    logic                 ok_reg;
    logic [8:0]           rbin_reg;
    logic signed [CW-1:0] xs, ys, dx, dy;
    logic signed [ZW-1:0] at;

    always_comb
    begin
        xs = CW'(in_item.x_mm) <<< 8;
        ys = CW'(in_item.y_mm) <<< 8;
        dx = x_reg >>> i_reg;
        dy = y_reg >>> i_reg;
        at = $signed(atan_entry(int'(i_reg)));
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            rbin_reg <= in_item.read_bin;
            i_reg    <= '0;
            ok_reg   <= in_item.point_valid && (in_item.z_mm <= cfg.height_max_mm)
                        && (in_item.z_mm >= cfg.height_min_mm);
            if (xs < 0)
            begin
                if (ys >= 0)
                begin
                    x_reg <= ys; y_reg <= -xs; z_reg <= ZW'(HALF_PI_Z);
                end
                else
                begin
                    x_reg <= -ys; y_reg <= xs; z_reg <= -ZW'(HALF_PI_Z);
                end
            end
            else
            begin
                x_reg <= xs; y_reg <= ys; z_reg <= '0;
            end
        end
        else if (ctl.cordic_step)
        begin
            i_reg <= i_reg + SCW'(1);
            if (y_reg >= 0)
            begin
                x_reg <= x_reg + dy; y_reg <= y_reg - dx; z_reg <= z_reg + at;
            end
            else
            begin
                x_reg <= x_reg - dy; y_reg <= y_reg + dx; z_reg <= z_reg - at;
            end
        end
    end

    // ---------------- range gain, angle ----------------
    logic [16:0]          rng_reg;     // saturated range, fits 16 bits
    logic signed [ANG_W:0] ang_reg;
    logic [CW-1:0]        xp;
    logic [CW+20-1:0]     prod;
    logic [CW+20-29:0]    rq;
    logic signed [ZW-1:0] zr;

    always_comb
    begin
        xp   = x_reg[CW-1] ? '0 : x_reg;
        prod = (CW+20)'(xp[31:0]) * (CW+20)'(INV_GAIN_Q20) + ((CW+20)'(1) << 27);
        rq   = prod[CW+20-1:28];
        zr   = (z_reg + ZW'(256)) >>> 9;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.gain)
        begin
            rng_reg <= (rq > 65535) ? 17'd65535 : 17'(rq);
            ang_reg <= (ANG_W+1)'(zr);
        end
    end

    logic signed [ANG_W:0] lo_e, hi_e;
    assign lo_e = (ANG_W+1)'(cfg.angle_low);
    assign hi_e = (ANG_W+1)'(cfg.angle_high);
    assign sts.keep = (rng_reg[15:0] >= cfg.min_dist_mm) && (ang_reg >= lo_e)
                      && (ang_reg <= hi_e);
    assign sts.in_range    = ok_reg;
    assign sts.cmd_read    = in_item.command;

    // ---------------- two restoring dividers ----------------
    // q = (ang-lo)/step; n = (span+step-1)/step
    logic [QW-1:0]    qa_reg, qn_reg;
    logic [QW-1:0]    ra_reg, rn_reg;
    logic [17:0]      d_reg;
    logic [4:0]       dc_reg;
    logic [QW:0]      ta, tn;
    logic signed [ANG_W:0] span;
    logic [QW-1:0]    span_num;
    logic [17:0]      stp;

    always_comb
    begin
        stp      = (cfg.angle_step == '0) ? 18'd1 : cfg.angle_step;
        span     = hi_e - lo_e;
        span_num = (span > 0) ? QW'(span) + QW'(stp) - QW'(1) : '0;
        ta       = {ra_reg, qa_reg[QW-1]};
        tn       = {rn_reg, qn_reg[QW-1]};
    end

    always_ff @(posedge clk)
    begin
        if (ctl.div_start)
        begin
            qa_reg <= QW'(ang_reg - lo_e);
            qn_reg <= span_num;
            ra_reg <= '0;
            rn_reg <= '0;
            d_reg  <= stp;
            dc_reg <= '0;
        end
        else if (ctl.div_step && dc_reg != 5'(QW))
        begin
            dc_reg <= dc_reg + 5'd1;
            if (ta >= (QW+1)'(d_reg))
            begin
                ra_reg <= QW'(ta - (QW+1)'(d_reg)); qa_reg <= {qa_reg[QW-2:0], 1'b1};
            end
            else
            begin
                ra_reg <= QW'(ta); qa_reg <= {qa_reg[QW-2:0], 1'b0};
            end
            if (tn >= (QW+1)'(d_reg))
            begin
                rn_reg <= QW'(tn - (QW+1)'(d_reg)); qn_reg <= {qn_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rn_reg <= QW'(tn); qn_reg <= {qn_reg[QW-2:0], 1'b0};
            end
        end
    end
    assign sts.div_done = (dc_reg == 5'(QW));

    logic [QW-1:0] last, nb;
    logic [BW-1:0] bidx;
    always_comb
    begin
        nb = (qn_reg == '0) ? QW'(1) : qn_reg;
        if (nb > QW'(MAX_BINS))
            nb = QW'(MAX_BINS);
        last = nb - QW'(1);
        bidx = (qa_reg > last) ? BW'(last) : BW'(qa_reg);
    end

    // ---------------- bin memory ----------------
    // bit 16 marks an occupied bin; a clearing pass empties all bins after reset
    logic [16:0]   mem [MAX_BINS];
    logic [16:0]   rd_reg;
    logic [BW-1:0] widx_reg;
    logic [BW-1:0] clr_reg;
    logic          inb;
    logic          rfull;
    logic [BW-1:0] ridx;

    assign inb   = (32'(rbin_reg) < 32'(MAX_BINS));
    assign ridx  = BW'(rbin_reg);
    assign rfull = inb && rd_reg[16];
    assign sts.clr_done = (clr_reg == BW'(MAX_BINS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else if (ctl.clr)
            clr_reg <= clr_reg + BW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mem_rd)
        begin
            rd_reg   <= mem[bidx];
            widx_reg <= bidx;
        end
        else if (ctl.rd_bin)
            rd_reg <= mem[ridx];
        if (ctl.clr)
            mem[clr_reg] <= '0;
        else if (ctl.rd_clr && inb)
            mem[ridx] <= '0;
        else if (ctl.update && (!rd_reg[16] || rng_reg[15:0] < rd_reg[15:0]))
            mem[widx_reg] <= {1'b1, rng_reg[15:0]};
    end

    logic [16:0] fill;
    always_comb
    begin
        fill = 17'(cfg.range_max_mm) + 17'd1000;
        if (fill > 17'd65535)
            fill = 17'd65535;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            res.bin_number <= rbin_reg;
            res.no_return  <= !rfull;
            res.range_mm   <= rfull ? rd_reg[15:0]
                              : (cfg.empty_as_infinity ? 16'd0 : fill[15:0]);
        end
    end
endmodule
`default_nettype wire

[rtl/core/point_cloud_polar_min_range_binner_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// channel  | dir | handshake           | payload
// in       | in  | in_valid/in_ready   | in_item_t
// out      | out | out_valid/out_ready | out_item_t
// cfg      | in  | cfg_we              | cfg_idx, cfg_data
// A point beat holds the block through iterative CORDIC, gain, check, a
// 19-step radix-2 divider plus its done check, bin read and bin write;
// dropped points finish early. A read beat reads the bin, empties it and
// then waits for a free output register.
// One item in flight; an unread result stalls the next read only.
// After reset a clearing pass empties the bins, with in_ready low.
module point_cloud_polar_min_range_binner_unit #(
    parameter int MAX_BINS     = pcpmrb_pkg::MAX_BINS_DEF,
    parameter int CORDIC_STEPS = pcpmrb_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire pcpmrb_pkg::in_item_t              in_item,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output pcpmrb_pkg::out_item_t                  out_item,
    input  wire logic                              cfg_we,
    input  wire logic [pcpmrb_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  wire logic [pcpmrb_pkg::CFG_DATA_W-1:0] cfg_data
);
    import pcpmrb_pkg::*;

    cfg_t   cfg_reg;
    ctl_t   ctl;
    sts_t   sts;
    logic   in_fire;
    logic   ov_reg;

    assign in_fire = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.height_min_mm     <= 16'sd0;
            cfg_reg.height_max_mm     <= 16'sd1000;
            cfg_reg.min_dist_mm       <= 16'd450;
            cfg_reg.range_max_mm      <= 16'd4000;
            cfg_reg.angle_low         <= -18'sd51472;
            cfg_reg.angle_high        <= 18'sd51472;
            cfg_reg.angle_step        <= 18'd286;
            cfg_reg.empty_as_infinity <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_HMIN:  cfg_reg.height_min_mm     <= cfg_data[15:0];
                REG_HMAX:  cfg_reg.height_max_mm     <= cfg_data[15:0];
                REG_RMIN:  cfg_reg.min_dist_mm       <= cfg_data[15:0];
                REG_RMAX:  cfg_reg.range_max_mm      <= cfg_data[15:0];
                REG_ALOW:  cfg_reg.angle_low         <= cfg_data;
                REG_AHIGH: cfg_reg.angle_high        <= cfg_data;
                REG_ASTEP: cfg_reg.angle_step        <= cfg_data;
                REG_INF:   cfg_reg.empty_as_infinity <= cfg_data[0];
                default:   ;
            endcase
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (ctl.out_load)
            ov_reg <= 1'b1;
        else if (out_ready)
            ov_reg <= 1'b0;
    end
    assign out_valid = ov_reg;

    pcpmrb_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .in_ready (in_ready),
        .out_free (!ov_reg || out_ready),
        .sts      (sts),
        .ctl      (ctl)
    );

    pcpmrb_dp #(.MAX_BINS(MAX_BINS), .CORDIC_STEPS(CORDIC_STEPS)) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_item (in_item),
        .cfg     (cfg_reg),
        .ctl     (ctl),
        .sts     (sts),
        .res     (out_item)
    );
endmodule
`default_nettype wire

[tb/sv/point_cloud_polar_min_range_binner_unit_tb.sv]
`timescale 1ns / 1ps
module point_cloud_polar_min_range_binner_unit_tb;
    import pcpmrb_pkg::*;

    // A point beat holds the block far longer than a read; the
    // receiver can stall for long runs at 82%, so the limit is generous.
    localparam int STALL_LIMIT = 20000;
    // A point beat makes no result, so before a register write we let the
    // worst-case point latency pass once the result queue is drained.
    localparam int DRAIN_CYCLES = 64;
    localparam int NUM_BINS = 512;
    localparam int IN_W = $bits(in_item_t);

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_item_t in_item;
    logic out_valid;
    logic out_ready;
    out_item_t out_item;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Shadow of the block: register copy and the bin memory.
    cfg_t cfg_shadow;
    logic [15:0] bin_min [NUM_BINS];
    bit bin_hit [NUM_BINS];

    // Expected read results, oldest first.
    out_item_t pending_reads [$];

    int fail_count;
    int idle_cycles;
    int send_idle_pct;
    int stall_pct;

    point_cloud_polar_min_range_binner_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Polar conversion: vectoring CORDIC on x,y scaled by 2^8.
    // Angle out in 2^-15 rad, range in mm (gain-corrected, saturated).
    // ------------------------------------------------------------------
    function automatic void cordic_polar(input int xi, input int yi,
                                         output int rng, output int ang);
        longint x;
        longint y;
        longint z;
        longint t;
        longint dx;
        longint dy;
        longint at;
        longint r;
        x = longint'(xi) * 256;
        y = longint'(yi) * 256;
        z = 0;
        // left half-plane: pre-rotate by 90 degrees
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                z = HALF_PI_Z;
            end
            else
            begin
                x = -y;
                y = t;
                z = -HALF_PI_Z;
            end
        end
        for (int i = 0; i < CORDIC_STEPS_DEF; i++)
        begin
            case (i)
                0: at = 13176795;
                1: at = 7778716;
                2: at = 4110060;
                3: at = 2086331;
                4: at = 1047214;
                5: at = 524117;
                6: at = 262123;
                7: at = 131069;
                default: at = longint'(1) << (24 - i);
            endcase
            dx = x >>> i;
            dy = y >>> i;
            if (y >= 0)
            begin
                x = x + dy;
                y = y - dx;
                z = z + at;
            end
            else
            begin
                x = x - dy;
                y = y + dx;
                z = z - at;
            end
        end
        if (x < 0)
            x = 0;
        r = (x * INV_GAIN_Q20 + (longint'(1) << 27)) >>> 28;
        rng = (r > 65535) ? 65535 : int'(r);
        ang = int'((z + 256) >>> 9);
    endfunction

    function automatic int angle_step_eff();
        return (cfg_shadow.angle_step == 0) ? 1 : int'(cfg_shadow.angle_step);
    endfunction

    // Number of live bins for the current angle window (at least 1).
    function automatic int live_bins();
        int span;
        int n;
        span = int'(cfg_shadow.angle_high) - int'(cfg_shadow.angle_low);
        n = (span > 0) ? (span + angle_step_eff() - 1) / angle_step_eff() : 0;
        if (n < 1)
            n = 1;
        if (n > NUM_BINS)
            n = NUM_BINS;
        return n;
    endfunction

    // Bin a point lands in, or -1 when the point is dropped.
    function automatic int landing_bin(input in_item_t it, output int rng);
        int ang;
        int q;
        rng = 0;
        if (!it.point_valid)
            return -1;
        if (int'(it.z_mm) > int'(cfg_shadow.height_max_mm) ||
            int'(it.z_mm) < int'(cfg_shadow.height_min_mm))
            return -1;
        cordic_polar(int'(it.x_mm), int'(it.y_mm), rng, ang);
        if (rng < int'(cfg_shadow.min_dist_mm))
            return -1;
        if (ang < int'(cfg_shadow.angle_low) || ang > int'(cfg_shadow.angle_high))
            return -1;
        q = (ang - int'(cfg_shadow.angle_low)) / angle_step_eff();
        if (q > live_bins() - 1)
            q = live_bins() - 1;
        return q;
    endfunction

    // Apply one accepted beat to the shadow; queue the read result if any.
    task automatic apply_beat(input in_item_t it);
        int q;
        int rng;
        int fill;
        out_item_t exp_item;
        if (it.command == CMD_ADD)
        begin
            q = landing_bin(it, rng);
            // equal range leaves the bin alone
            if (q >= 0 && (!bin_hit[q] || rng < bin_min[q]))
            begin
                bin_min[q] = 16'(rng);
                bin_hit[q] = 1'b1;
            end
        end
        else
        begin
            exp_item.bin_number = it.read_bin;
            if (bin_hit[it.read_bin])
            begin
                exp_item.range_mm = bin_min[it.read_bin];
                exp_item.no_return = 1'b0;
            end
            else
            begin
                fill = int'(cfg_shadow.range_max_mm) + 1000;
                if (fill > 65535)
                    fill = 65535;
                exp_item.range_mm = cfg_shadow.empty_as_infinity ? 16'd0 : 16'(fill);
                exp_item.no_return = 1'b1;
            end
            bin_hit[it.read_bin] = 1'b0;
            bin_min[it.read_bin] = '0;
            pending_reads.push_back(exp_item);
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        fail_count++;
    endtask

    // Send one beat; the shadow is updated at the accepting edge.
    task automatic send_beat(input in_item_t it);
        while ($urandom_range(99) < send_idle_pct)
            @(negedge clk);
        in_item = it;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        apply_beat(it);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // Wait until every read result is back, then let a point finish.
    task automatic drain();
        while (pending_reads.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_idx = idx;
        cfg_data = CFG_DATA_W'(value);
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            REG_HMIN:  cfg_shadow.height_min_mm = 16'(value);
            REG_HMAX:  cfg_shadow.height_max_mm = 16'(value);
            REG_RMIN:  cfg_shadow.min_dist_mm = 16'(value);
            REG_RMAX:  cfg_shadow.range_max_mm = 16'(value);
            REG_ALOW:  cfg_shadow.angle_low = 18'(value);
            REG_AHIGH: cfg_shadow.angle_high = 18'(value);
            REG_ASTEP: cfg_shadow.angle_step = 18'(value);
            REG_INF:   cfg_shadow.empty_as_infinity = 1'(value);
            default: ;
        endcase
    endtask

    task automatic load_config(input int hmin, input int hmax, input int rmin,
                               input int rmax, input int alow, input int ahigh,
                               input int astep, input int inf);
        drain();
        write_reg(REG_HMIN, hmin);
        write_reg(REG_HMAX, hmax);
        write_reg(REG_RMIN, rmin);
        write_reg(REG_RMAX, rmax);
        write_reg(REG_ALOW, alow);
        write_reg(REG_AHIGH, ahigh);
        write_reg(REG_ASTEP, astep);
        write_reg(REG_INF, inf);
    endtask

    function automatic in_item_t make_point(input int x, input int y, input int z,
                                            input bit ok);
        in_item_t it;
        it = '0;
        it.command = CMD_ADD;
        it.x_mm = 16'(x);
        it.y_mm = 16'(y);
        it.z_mm = 16'(z);
        it.point_valid = ok;
        it.read_bin = 9'($urandom);
        return it;
    endfunction

    function automatic in_item_t make_read(input int idx);
        in_item_t it;
        it = in_item_t'(IN_W'({$urandom, $urandom, $urandom}));
        it.command = CMD_READ;
        it.read_bin = 9'(idx);
        return it;
    endfunction

    // Add a point, then read back the bin it should land in (bin 0 if dropped).
    task automatic point_then_read(input int x, input int y, input int z, input bit ok);
        in_item_t it;
        int q;
        int rng;
        it = make_point(x, y, z, ok);
        q = landing_bin(it, rng);
        send_beat(it);
        send_beat(make_read(q < 0 ? 0 : q));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_empty_after_reset();
        send_beat(make_read(0));
        send_beat(make_read(NUM_BINS - 1));
    endtask

    task automatic test_point_extremes();
        point_then_read(0, 0, 0, 1'b1);            // origin: range 0, below min distance
        point_then_read(1000, 0, 500, 1'b1);
        point_then_read(1000, 0, 500, 1'b0);       // invalid point
        point_then_read(1000, 0, 1001, 1'b1);      // above height window
        point_then_read(1000, 0, -1, 1'b1);        // below height window
        point_then_read(-32768, -32768, 0, 1'b1);  // far corner, outside the angle window
        point_then_read(32767, 32767, 1000, 1'b1);
        point_then_read(-32768, 32767, 0, 1'b1);
        point_then_read(100, 2000, 10, 1'b1);      // near the upper angle edge
        point_then_read(100, -2000, 10, 1'b1);
    endtask

    task automatic test_window_corners();
        // Zero step, extreme angles, full range window, fill at its 16-bit maximum.
        load_config(-32768, 32767, 0, 64535, -102944, 102944, 0, 0);
        point_then_read(-32768, 1, -32768, 1'b1);
        point_then_read(-32768, -1, 32767, 1'b1);
        // Tie: second point with equal range keeps the bin as is
        send_beat(make_point(3000, 5, 0, 1'b1));
        point_then_read(3000, 5, 0, 1'b1);
        // Inverted height and angle windows drop every point
        load_config(10, -10, 0, 0, 1000, -1000, 205888, 1);
        point_then_read(500, 0, 0, 1'b1);
        load_config(-1000, 1000, 46341, 0, 0, 0, 1, 0);
        point_then_read(32767, 32767, 0, 1'b1);
        point_then_read(-32768, 0, 0, 1'b1);
    endtask

    // Mostly well-formed points and reads of live bins, some raw noise.
    task automatic random_phase(input int beats);
        in_item_t it;
        int pick;
        int zlo;
        int zhi;
        for (int n = 0; n < beats; n++)
        begin
            pick = $urandom_range(99);
            zlo = int'(cfg_shadow.height_min_mm);
            zhi = int'(cfg_shadow.height_max_mm);
            if (pick < 12)
                it = in_item_t'(IN_W'({$urandom, $urandom, $urandom}));
            else if (pick < 35)
                it = make_read($urandom_range(live_bins() - 1));
            else
            begin
                it = make_point($urandom_range(8000) - 4000,
                                $urandom_range(8000) - 4000,
                                (zlo <= zhi) ? zlo + $urandom_range(zhi - zlo) : $urandom,
                                $urandom_range(19) != 0);
            end
            send_beat(it);
        end
    endtask

    task automatic test_random_traffic();
        send_idle_pct = 20;
        stall_pct = 82;
        load_config(0, 1000, 450, 4000, -51472, 51472, 286, 1);
        random_phase(567);
        send_idle_pct = 82;
        stall_pct = 20;
        load_config(-32768, 32767, 0, 64535, -102944, 102944, 1, 0);
        random_phase(567);
        send_idle_pct = 0;
        stall_pct = 0;
        load_config(-200, 200, 100, 12345, -102944, 102944, 205888, 0);
        random_phase(300);
        load_config(-5000, 5000, 300, 2000, -30000, 40000, 700, 1);
        random_phase(270);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, results checked at the accepting edge.
    // ------------------------------------------------------------------
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_reads.size() == 0)
                report_mismatch($sformatf("unexpected result bin %0d", out_item.bin_number));
            else
            begin
                want = pending_reads.pop_front();
                if (out_item.bin_number !== want.bin_number)
                    report_mismatch($sformatf("bin_number got %0d want %0d",
                                              out_item.bin_number, want.bin_number));
                if (out_item.range_mm !== want.range_mm)
                    report_mismatch($sformatf("bin %0d range_mm got %0d want %0d",
                                              want.bin_number, out_item.range_mm,
                                              want.range_mm));
                if (out_item.no_return !== want.no_return)
                    report_mismatch($sformatf("bin %0d no_return got %0b want %0b",
                                              want.bin_number, out_item.no_return,
                                              want.no_return));
            end
        end
    end

    // Watchdog: cycles with no beat on any port.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        out_ready = 1'b0;
        fail_count = 0;
        idle_cycles = 0;
        send_idle_pct = 20;
        stall_pct = 82;
        cfg_shadow = '{16'sd0, 16'sd1000, 16'd450, 16'd4000,
                       -18'sd51472, 18'sd51472, 18'd286, 1'b1};
        foreach (bin_hit[i])
        begin
            bin_hit[i] = 1'b0;
            bin_min[i] = '0;
        end
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_after_reset();
        test_point_extremes();
        test_window_corners();
        test_random_traffic();

        drain();
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
